// ===== rtl/rtt_pkg.sv =====
// types and constants shared by the timer table front end, back end and checker
// depends on nothing

package rtt_pkg;

   // table size limit, keeps every entry addressable by a 4-bit index
   localparam int TABLE_CAP = 16;

   // command queue between front and back end
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   // field widths
   localparam int OP_W     = 2;
   localparam int INDEX_W  = 4;
   localparam int IVL_W    = 24;
   localparam int TIME_W   = 32;
   localparam int COUNT_W  = 32;
   localparam int STATUS_W = 3;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [OP_W-1:0] {
      OP_CREATE = 2'd0,
      OP_SET    = 2'd1,
      OP_STOP   = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      RS_DONE    = 3'd0,
      RS_FULL    = 3'd1,
      RS_IGNORED = 3'd2,
      RS_FIRED   = 3'd3,
      RS_NO_FIRE = 3'd4
   } rsp_status_type;

   typedef enum logic [1:0] {
      ENT_UNUSED  = 2'd0,
      ENT_IDLE    = 2'd1,
      ENT_RUNNING = 2'd2
   } ent_state_type;

   typedef enum logic [1:0] {
      BK_IDLE   = 2'd0,
      BK_WALK   = 2'd1,
      BK_FINISH = 2'd2
   } bk_state_type;

   // classified command as it leaves the front end
   typedef struct packed {
      op_type             op;
      logic [INDEX_W-1:0] idx;
      logic [IVL_W-1:0]   interval;
      logic               mode;
      logic               susp;
      logic               in_range;
   } cmd_type;

   // one result transaction
   typedef struct packed {
      rsp_status_type     status;
      logic [INDEX_W-1:0] idx;
      logic [COUNT_W-1:0] count;
      logic               last;
   } rsp_type;

endpackage

// ===== rtl/rtt_front.sv =====
// front end of the timer table: accepts request transactions, classifies them
// and holds them in a short command queue; depends on rtt_pkg

module rtt_front #(
   parameter int NSLOT = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // timer_index[3:0], interval[27:4], timer_mode[28], suspended[29], zero fill
   input  logic [rtt_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation[1:0]
   input  logic [rtt_pkg::OP_W-1:0]       req_tuser,
   output logic                           q_valid,
   output rtt_pkg::cmd_type               q_cmd,
   input  logic                           q_pop
);

   localparam logic [rtt_pkg::INDEX_W:0] SLOT_LIM = (rtt_pkg::INDEX_W+1)'(NSLOT);

   rtt_pkg::cmd_type                    cmd_ff [rtt_pkg::QUEUE_DEPTH];
   rtt_pkg::cmd_type                    cmd_in;
   logic [rtt_pkg::QPTR_W-1:0]          wr_ff, wr_in, rd_ff, rd_in;
   logic [rtt_pkg::QPTR_W:0]            cnt_ff, cnt_in;
   logic                                push;

   // classify the incoming transaction
   always_comb begin
      cmd_in.op       = rtt_pkg::op_type'(req_tuser);
      cmd_in.idx      = req_tdata[3:0];
      cmd_in.interval = req_tdata[27:4];
      cmd_in.mode     = req_tdata[28];
      cmd_in.susp     = req_tdata[29];
      cmd_in.in_range = ({1'b0, req_tdata[3:0]} < SLOT_LIM);
   end

   // queue occupancy and pointers
   assign req_tready = (cnt_ff != (rtt_pkg::QPTR_W+1)'(rtt_pkg::QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != '0);
   assign q_cmd      = cmd_ff[rd_ff];

   always_comb begin
      wr_in  = push  ? wr_ff + 1'b1 : wr_ff;
      rd_in  = q_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (rtt_pkg::QPTR_W+1)'(push) - (rtt_pkg::QPTR_W+1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         cmd_ff[wr_ff] <= cmd_in;
      end
   end

endmodule

// ===== rtl/rtt_back.sv =====
// back end of the timer table: holds the entries and the time base, carries out
// queued commands, walks the table on a tick; depends on rtt_pkg

module rtt_back #(
   parameter  int NSLOT = 16,
   localparam int IDX_W = (NSLOT > 1) ? $clog2(NSLOT) : 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  rtt_pkg::cmd_type               q_cmd,
   output logic                           q_pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rtt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [rtt_pkg::STATUS_W-1:0]   rsp_tuser,
   output logic                           rsp_tlast
);

   localparam logic [IDX_W-1:0] WALK_LAST = IDX_W'(NSLOT - 1);

   // entry table
   rtt_pkg::ent_state_type              status_ff [NSLOT];
   rtt_pkg::ent_state_type              status_in [NSLOT];
   logic                                cont_ff   [NSLOT];
   logic                                cont_in   [NSLOT];
   logic [rtt_pkg::IVL_W-1:0]           ivl_ff    [NSLOT];
   logic [rtt_pkg::IVL_W-1:0]           ivl_in    [NSLOT];
   logic [rtt_pkg::TIME_W-1:0]          exp_ff    [NSLOT];
   logic [rtt_pkg::TIME_W-1:0]          exp_in    [NSLOT];
   logic [rtt_pkg::COUNT_W-1:0]         fired_ff  [NSLOT];
   logic [rtt_pkg::COUNT_W-1:0]         fired_in  [NSLOT];

   logic [rtt_pkg::TIME_W-1:0]          now_ff, now_in;
   rtt_pkg::bk_state_type               state_ff, state_in;
   logic [IDX_W-1:0]                    walk_ff, walk_in;
   logic                                pend_v_ff, pend_v_in;
   logic [rtt_pkg::INDEX_W-1:0]         pend_idx_ff, pend_idx_in;
   logic [rtt_pkg::COUNT_W-1:0]         pend_cnt_ff, pend_cnt_in;

   logic                                rsp_v_ff;
   rtt_pkg::rsp_type                    rsp_ff, rsp_in;
   logic                                rsp_load;
   logic                                out_free;

   logic                                free_found;
   logic [IDX_W-1:0]                    free_idx;
   logic [IDX_W-1:0]                    a_idx;
   logic [rtt_pkg::COUNT_W-1:0]         a_cnt;
   logic [rtt_pkg::TIME_W-1:0]          w_diff;
   logic                                w_due;
   logic                                walk_step;
   logic                                walk_end;

   assign out_free = !rsp_v_ff || rsp_tready;

   // lowest unused entry for create
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NSLOT - 1; i >= 0; i--) begin
         if (status_ff[i] == rtt_pkg::ENT_UNUSED) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   // addressed entry for set and stop, unused entries report a zero count
   assign a_idx = q_cmd.idx[IDX_W-1:0];
   assign a_cnt = (status_ff[a_idx] == rtt_pkg::ENT_UNUSED) ? '0 : fired_ff[a_idx];

   // wrap-safe expiry compare on the walked entry
   assign w_diff    = now_ff - exp_ff[walk_ff];
   assign w_due     = (status_ff[walk_ff] == rtt_pkg::ENT_RUNNING) && !w_diff[rtt_pkg::TIME_W-1];
   assign walk_step = !w_due || !pend_v_ff || out_free;
   assign walk_end  = (walk_ff == WALK_LAST);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rtt_pkg::BK_IDLE: begin
            if (q_valid && q_cmd.op == rtt_pkg::OP_TICK) begin
               state_in = q_cmd.susp ? rtt_pkg::BK_FINISH : rtt_pkg::BK_WALK;
            end
         end
         rtt_pkg::BK_WALK: begin
            if (walk_step && walk_end) begin
               state_in = rtt_pkg::BK_FINISH;
            end
         end
         rtt_pkg::BK_FINISH: begin
            if (out_free) begin
               state_in = rtt_pkg::BK_IDLE;
            end
         end
         default: state_in = rtt_pkg::BK_IDLE;
      endcase
   end

   // command execution, table updates and result selection
   always_comb begin
      status_in   = status_ff;
      cont_in     = cont_ff;
      ivl_in      = ivl_ff;
      exp_in      = exp_ff;
      fired_in    = fired_ff;
      now_in      = now_ff;
      walk_in     = walk_ff;
      pend_v_in   = pend_v_ff;
      pend_idx_in = pend_idx_ff;
      pend_cnt_in = pend_cnt_ff;
      rsp_load    = 1'b0;
      rsp_in      = '0;
      q_pop       = 1'b0;
      unique case (state_ff)
         rtt_pkg::BK_IDLE: begin
            if (q_valid) begin
               unique case (q_cmd.op)
                  rtt_pkg::OP_TICK: begin
                     q_pop     = 1'b1;
                     now_in    = now_ff + 1'b1;
                     walk_in   = '0;
                     pend_v_in = 1'b0;
                  end
                  rtt_pkg::OP_CREATE: begin
                     if (out_free) begin
                        q_pop    = 1'b1;
                        rsp_load = 1'b1;
                        if (free_found) begin
                           status_in[free_idx] = rtt_pkg::ENT_IDLE;
                           cont_in[free_idx]   = q_cmd.mode;
                           ivl_in[free_idx]    = '0;
                           exp_in[free_idx]    = '0;
                           fired_in[free_idx]  = '0;
                           rsp_in = '{rtt_pkg::RS_DONE, rtt_pkg::INDEX_W'(free_idx), '0, 1'b1};
                        end else begin
                           rsp_in = '{rtt_pkg::RS_FULL, '0, '0, 1'b1};
                        end
                     end
                  end
                  rtt_pkg::OP_SET: begin
                     if (out_free) begin
                        q_pop    = 1'b1;
                        rsp_load = 1'b1;
                        if (!q_cmd.in_range) begin
                           rsp_in = '{rtt_pkg::RS_IGNORED, q_cmd.idx, '0, 1'b1};
                        end else if (q_cmd.interval == '0 ||
                                     status_ff[a_idx] == rtt_pkg::ENT_UNUSED) begin
                           rsp_in = '{rtt_pkg::RS_IGNORED, q_cmd.idx, a_cnt, 1'b1};
                        end else begin
                           ivl_in[a_idx] = q_cmd.interval;
                           // a running continuous timer keeps its expiry
                           if (!(cont_ff[a_idx] && status_ff[a_idx] == rtt_pkg::ENT_RUNNING)) begin
                              exp_in[a_idx]    = now_ff + rtt_pkg::TIME_W'(q_cmd.interval);
                              status_in[a_idx] = rtt_pkg::ENT_RUNNING;
                           end
                           rsp_in = '{rtt_pkg::RS_DONE, q_cmd.idx, a_cnt, 1'b1};
                        end
                     end
                  end
                  rtt_pkg::OP_STOP: begin
                     if (out_free) begin
                        q_pop    = 1'b1;
                        rsp_load = 1'b1;
                        if (!q_cmd.in_range) begin
                           rsp_in = '{rtt_pkg::RS_IGNORED, q_cmd.idx, '0, 1'b1};
                        end else if (status_ff[a_idx] != rtt_pkg::ENT_RUNNING) begin
                           rsp_in = '{rtt_pkg::RS_IGNORED, q_cmd.idx, a_cnt, 1'b1};
                        end else begin
                           status_in[a_idx] = rtt_pkg::ENT_IDLE;
                           rsp_in = '{rtt_pkg::RS_DONE, q_cmd.idx, a_cnt, 1'b1};
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         rtt_pkg::BK_WALK: begin
            // one entry a cycle unless a due entry meets a pending firing and a stalled result;
            // a firing is held back until the next one shows whether it is the final result of the tick
            if (walk_step) begin
               walk_in = walk_ff + 1'b1;
               if (w_due) begin
                  if (cont_ff[walk_ff]) begin
                     exp_in[walk_ff] = exp_ff[walk_ff] + rtt_pkg::TIME_W'(ivl_ff[walk_ff]);
                  end else begin
                     status_in[walk_ff] = rtt_pkg::ENT_IDLE;
                  end
                  fired_in[walk_ff] = fired_ff[walk_ff] + 1'b1;
                  if (pend_v_ff) begin
                     rsp_load = 1'b1;
                     rsp_in   = '{rtt_pkg::RS_FIRED, pend_idx_ff, pend_cnt_ff, 1'b0};
                  end
                  pend_v_in   = 1'b1;
                  pend_idx_in = rtt_pkg::INDEX_W'(walk_ff);
                  pend_cnt_in = fired_ff[walk_ff] + 1'b1;
               end
            end
         end
         rtt_pkg::BK_FINISH: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if (pend_v_ff) begin
                  rsp_in = '{rtt_pkg::RS_FIRED, pend_idx_ff, pend_cnt_ff, 1'b1};
               end else begin
                  rsp_in = '{rtt_pkg::RS_NO_FIRE, '0, '0, 1'b1};
               end
               pend_v_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rtt_pkg::BK_IDLE;
         now_ff    <= '0;
         pend_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
         for (int i = 0; i < NSLOT; i++) begin
            status_ff[i] <= rtt_pkg::ENT_UNUSED;
         end
      end else begin
         state_ff  <= state_in;
         now_ff    <= now_in;
         pend_v_ff <= pend_v_in;
         status_ff <= status_in;
         if (rsp_load) begin
            rsp_v_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_v_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cont_ff     <= cont_in;
      ivl_ff      <= ivl_in;
      exp_ff      <= exp_in;
      fired_ff    <= fired_in;
      walk_ff     <= walk_in;
      pend_idx_ff <= pend_idx_in;
      pend_cnt_ff <= pend_cnt_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // result port
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {4'b0000, rsp_ff.count, rsp_ff.idx};
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tlast  = rsp_ff.last;

endmodule

// ===== rtl/realtime_timer_table.sv =====
// Timer table with one-shot and continuous timers.
// Request channel (req_*): one transaction per command, the operation in tuser
// (create, set interval and start, stop, tick); index, interval, mode and the
// suspend flag in tdata.
// Result channel (rsp_*): status in tuser, entry index and fire count in tdata,
// tlast on the final result of a command. Create, set and stop give one result;
// a tick gives one result per fired entry in ascending order, or a single
// no-fire result.
// Create, set and stop are carried out directly by the back end. A tick walks
// every entry of the table (capped table size), one entry a cycle while the
// result path is clear; a suspended tick skips the walk.
// An accepted command waits in the command queue, and its result is held in
// the result register until the receiver takes it.
// A two-entry command queue sits between request decode and execution, so
// requests are still taken while a result waits. A stalled receiver holds the
// result register and pauses the walk at a firing while another is pending.
// Reset empties the table, zeroes the time base and the queue; no clearing pass.
// Depends on rtt_pkg, rtt_front and rtt_back.

module realtime_timer_table #(
   parameter int TIMERS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // timer_index[3:0], interval[27:4], timer_mode[28], suspended[29], zero fill
   input  logic [rtt_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation[1:0]
   input  logic [rtt_pkg::OP_W-1:0]       req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // entry_index[3:0], fire_count[35:4], zero fill
   output logic [rtt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status[2:0]
   output logic [rtt_pkg::STATUS_W-1:0]   rsp_tuser,
   output logic                           rsp_tlast
);

   localparam int NSLOT = (TIMERS < rtt_pkg::TABLE_CAP) ? TIMERS : rtt_pkg::TABLE_CAP;

   logic             q_valid;
   logic             q_pop;
   rtt_pkg::cmd_type q_cmd;

   rtt_front #(
      .NSLOT (NSLOT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop)
   );

   rtt_back #(
      .NSLOT (NSLOT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/rtt_checker.sv =====
// port-level checks for the timer table, attached by bind
// depends on rtt_pkg and realtime_timer_table

module rtt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [rtt_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [rtt_pkg::OP_W-1:0]       req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [rtt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [rtt_pkg::STATUS_W-1:0]   rsp_tuser,
   input logic                           rsp_tlast
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // only firings can be followed by further results of the same command
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != rtt_pkg::RS_FIRED |-> rsp_tlast)
      else $error("non-firing result without tlast");

   // full table and no-fire results carry zero index and count
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == rtt_pkg::RS_FULL || rsp_tuser == rtt_pkg::RS_NO_FIRE)
      |-> rsp_tdata == '0)
      else $error("full or no-fire result with nonzero fields");

   // a fired entry has fired at least once
   a_fired_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == rtt_pkg::RS_FIRED |-> rsp_tdata[35:4] != '0 ||
      $past(rsp_tvalid))
      else $error("firing reported with zero count");

endmodule

bind realtime_timer_table rtt_checker u_rtt_checker (.*);

// ===== dv/timer_table_checker.sv =====
`timescale 1ns / 100ps
// checker for the timer table: watches both streams, predicts every result from
// its own copy of the table and compares each result transaction in order
// depends on rtt_pkg

module timer_table_checker #(
   parameter int TIMERS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // timer_index[3:0], interval[27:4], timer_mode[28], suspended[29], zero fill
   input  logic [rtt_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation[1:0]
   input  logic [rtt_pkg::OP_W-1:0]       req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // entry_index[3:0], fire_count[35:4], zero fill
   input  logic [rtt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // status[2:0]
   input  logic [rtt_pkg::STATUS_W-1:0]   rsp_tuser,
   input  logic                           rsp_tlast,
   output int unsigned                    mismatch_count,
   output int unsigned                    results_owed,
   output int unsigned                    results_checked,
   output int unsigned                    firings_seen,
   output int unsigned                    widest_tick
);

   localparam int SLOTS = (TIMERS < rtt_pkg::TABLE_CAP) ? TIMERS : rtt_pkg::TABLE_CAP;

   // shadow copy of the timer table
   rtt_pkg::ent_state_type      ent_state  [rtt_pkg::TABLE_CAP];
   logic                        ent_cont   [rtt_pkg::TABLE_CAP];
   logic [rtt_pkg::IVL_W-1:0]   ent_ivl    [rtt_pkg::TABLE_CAP];
   logic [rtt_pkg::TIME_W-1:0]  ent_expiry [rtt_pkg::TABLE_CAP];
   logic [rtt_pkg::COUNT_W-1:0] ent_fired  [rtt_pkg::TABLE_CAP];
   logic [rtt_pkg::TIME_W-1:0]  now_ticks;

   // results still owed by the block, oldest first
   rtt_pkg::rsp_type expected_rsp_q[$];
   rtt_pkg::rsp_type observed;
   rtt_pkg::rsp_type wanted;

   function automatic rtt_pkg::rsp_type make_rsp(input rtt_pkg::rsp_status_type status,
                                                 input logic [rtt_pkg::INDEX_W-1:0] idx,
                                                 input logic [rtt_pkg::COUNT_W-1:0] count,
                                                 input logic last);
      rtt_pkg::rsp_type r;
      r.status = status;
      r.idx    = idx;
      r.count  = count;
      r.last   = last;
      return r;
   endfunction

   // advance the shadow table by one command and queue the results it causes
   task automatic predict_command(input rtt_pkg::op_type op,
                                  input logic [rtt_pkg::INDEX_W-1:0] idx,
                                  input logic [rtt_pkg::IVL_W-1:0] ivl, input logic mode,
                                  input logic susp);
      logic [rtt_pkg::TABLE_CAP-1:0] due;
      logic [rtt_pkg::TIME_W-1:0]    lag;
      int                            last_due;
      int                            i;
      bit                            found;
      found    = 1'b0;
      due      = '0;
      last_due = -1;
      case (op)
         rtt_pkg::OP_CREATE: begin
            // lowest unused entry wins
            for (i = 0; i < SLOTS; i++) begin
               if (!found && ent_state[i] == rtt_pkg::ENT_UNUSED) begin
                  found         = 1'b1;
                  ent_state[i]  = rtt_pkg::ENT_IDLE;
                  ent_cont[i]   = mode;
                  ent_ivl[i]    = '0;
                  ent_expiry[i] = '0;
                  ent_fired[i]  = '0;
                  expected_rsp_q.push_back(make_rsp(rtt_pkg::RS_DONE,
                                                    rtt_pkg::INDEX_W'(i), '0, 1'b1));
               end
            end
            if (!found)
               expected_rsp_q.push_back(make_rsp(rtt_pkg::RS_FULL, '0, '0, 1'b1));
         end
         rtt_pkg::OP_SET: begin
            if (idx >= SLOTS) begin
               expected_rsp_q.push_back(make_rsp(rtt_pkg::RS_IGNORED, idx, '0, 1'b1));
            end else if (ivl == '0 || ent_state[idx] == rtt_pkg::ENT_UNUSED) begin
               expected_rsp_q.push_back(make_rsp(rtt_pkg::RS_IGNORED, idx,
                                                 ent_fired[idx], 1'b1));
            end else begin
               ent_ivl[idx] = ivl;
               // a running continuous timer keeps its expiry
               if (!(ent_cont[idx] && ent_state[idx] == rtt_pkg::ENT_RUNNING)) begin
                  ent_expiry[idx] = now_ticks + ivl;
                  ent_state[idx]  = rtt_pkg::ENT_RUNNING;
               end
               expected_rsp_q.push_back(make_rsp(rtt_pkg::RS_DONE, idx, ent_fired[idx],
                                                 1'b1));
            end
         end
         rtt_pkg::OP_STOP: begin
            if (idx >= SLOTS) begin
               expected_rsp_q.push_back(make_rsp(rtt_pkg::RS_IGNORED, idx, '0, 1'b1));
            end else if (ent_state[idx] != rtt_pkg::ENT_RUNNING) begin
               expected_rsp_q.push_back(make_rsp(rtt_pkg::RS_IGNORED, idx,
                                                 ent_fired[idx], 1'b1));
            end else begin
               ent_state[idx] = rtt_pkg::ENT_IDLE;
               expected_rsp_q.push_back(make_rsp(rtt_pkg::RS_DONE, idx, ent_fired[idx],
                                                 1'b1));
            end
         end
         default: begin
            now_ticks = now_ticks + 1'b1;
            if (!susp) begin
               // wrap-safe due test first, so the final firing is known
               for (i = 0; i < SLOTS; i++) begin
                  lag = now_ticks - ent_expiry[i];
                  if (ent_state[i] == rtt_pkg::ENT_RUNNING && !lag[rtt_pkg::TIME_W-1]) begin
                     due[i]   = 1'b1;
                     last_due = i;
                  end
               end
               for (i = 0; i < SLOTS; i++) begin
                  if (due[i]) begin
                     if (ent_cont[i])
                        ent_expiry[i] = ent_expiry[i] + ent_ivl[i];
                     else
                        ent_state[i] = rtt_pkg::ENT_IDLE;
                     ent_fired[i] = ent_fired[i] + 1'b1;
                     expected_rsp_q.push_back(make_rsp(rtt_pkg::RS_FIRED,
                                                       rtt_pkg::INDEX_W'(i), ent_fired[i],
                                                       i == last_due));
                  end
               end
            end
            if (last_due < 0)
               expected_rsp_q.push_back(make_rsp(rtt_pkg::RS_NO_FIRE, '0, '0, 1'b1));
            else if ($countones(due) > widest_tick)
               widest_tick = $countones(due);
         end
      endcase
   endtask

   // result check first, then prediction for a command taken at the same edge
   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < rtt_pkg::TABLE_CAP; k++) begin
            ent_state[k]  = rtt_pkg::ENT_UNUSED;
            ent_cont[k]   = 1'b0;
            ent_ivl[k]    = '0;
            ent_expiry[k] = '0;
            ent_fired[k]  = '0;
         end
         now_ticks = '0;
         expected_rsp_q.delete();
         mismatch_count  = 0;
         results_checked = 0;
         firings_seen    = 0;
         widest_tick     = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            observed.status = rtt_pkg::rsp_status_type'(rsp_tuser);
            observed.idx    = rsp_tdata[rtt_pkg::INDEX_W-1:0];
            observed.count  = rsp_tdata[rtt_pkg::INDEX_W +: rtt_pkg::COUNT_W];
            observed.last   = rsp_tlast;
            results_checked++;
            if (observed.status == rtt_pkg::RS_FIRED)
               firings_seen++;
            if (expected_rsp_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result status %0d entry %0d count %0d last %0d",
                           $time, observed.status, observed.idx, observed.count,
                           observed.last);
            end else begin
               wanted = expected_rsp_q.pop_front();
               if (observed.status !== wanted.status || observed.idx !== wanted.idx ||
                   observed.count !== wanted.count || observed.last !== wanted.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0t: result mismatch, expected status %0d entry %0d ",
                               "count %0d last %0d, got status %0d entry %0d count %0d ",
                               "last %0d"}, $time, wanted.status, wanted.idx,
                              wanted.count, wanted.last, observed.status, observed.idx,
                              observed.count, observed.last);
               end
            end
         end
         if (req_tvalid && req_tready)
            predict_command(rtt_pkg::op_type'(req_tuser), req_tdata[rtt_pkg::INDEX_W-1:0],
                            req_tdata[rtt_pkg::INDEX_W +: rtt_pkg::IVL_W],
                            req_tdata[rtt_pkg::INDEX_W + rtt_pkg::IVL_W],
                            req_tdata[rtt_pkg::INDEX_W + rtt_pkg::IVL_W + 1]);
      end
      results_owed = expected_rsp_q.size();
   end

endmodule

// ===== dv/tb_realtime_timer_table.sv =====
`timescale 1ns / 100ps
// top of the timer table testbench: clock, reset, command stimulus, result
// back-pressure and the verdict; checking is done in timer_table_checker
// depends on rtt_pkg, realtime_timer_table and timer_table_checker

module tb_realtime_timer_table;

   localparam int TIMERS       = 16;
   localparam int RANDOM_ITEMS = 390;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 40;

   // receiver back-pressure styles
   localparam int RDY_FREE    = 0;
   localparam int RDY_COIN    = 1;
   localparam int RDY_SPARSE  = 2;
   localparam int RDY_CADENCE = 3;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [rtt_pkg::REQ_DATA_W-1:0]   req_tdata;
   logic [rtt_pkg::OP_W-1:0]         req_tuser;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [rtt_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic [rtt_pkg::STATUS_W-1:0]     rsp_tuser;
   logic                             rsp_tlast;

   int unsigned mismatch_count;
   int unsigned results_owed;
   int unsigned results_checked;
   int unsigned firings_seen;
   int unsigned widest_tick;

   int unsigned commands_sent = 0;
   int unsigned ticks_sent    = 0;
   int          burst_left    = 0;
   bit          hold_off_req  = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   realtime_timer_table #(
      .TIMERS(TIMERS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   timer_table_checker #(
      .TIMERS(TIMERS)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .rsp_tlast       (rsp_tlast),
      .mismatch_count  (mismatch_count),
      .results_owed    (results_owed),
      .results_checked (results_checked),
      .firings_seen    (firings_seen),
      .widest_tick     (widest_tick)
   );

   // offer one command and hold it until taken; bursts end in a random gap
   task automatic send_command(input rtt_pkg::op_type op,
                               input logic [rtt_pkg::INDEX_W-1:0] idx,
                               input logic [rtt_pkg::IVL_W-1:0] ivl, input logic mode,
                               input logic susp);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, susp, mode, ivl, idx};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      commands_sent++;
      if (op == rtt_pkg::OP_TICK)
         ticks_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap        = $urandom_range(1, 14);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering until every owed result has been taken
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (results_owed == 0);
      @(posedge clock);
   endtask

   // command stimulus
   initial begin
      rtt_pkg::op_type           op;
      int                        pick;
      int                        n;
      logic [rtt_pkg::IVL_W-1:0] ivl;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= rtt_pkg::OP_CREATE;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, each operation and its ignored forms
      send_command(rtt_pkg::OP_TICK,   4'd0,  24'd0, 1'b0, 1'b0);   // nothing to fire
      send_command(rtt_pkg::OP_CREATE, 4'd0,  24'd0, 1'b0, 1'b0);   // one-shot in entry 0
      send_command(rtt_pkg::OP_CREATE, 4'd0,  24'd0, 1'b1, 1'b0);   // continuous in entry 1
      send_command(rtt_pkg::OP_SET,    4'd15, 24'd5, 1'b0, 1'b0);   // unused entry
      send_command(rtt_pkg::OP_STOP,   4'd1,  24'd0, 1'b0, 1'b0);   // stop on idle entry
      send_command(rtt_pkg::OP_SET,    4'd0,  24'd0, 1'b0, 1'b0);   // zero interval
      send_command(rtt_pkg::OP_SET,    4'd0,  24'd1, 1'b0, 1'b0);
      send_command(rtt_pkg::OP_SET,    4'd1,  24'd2, 1'b0, 1'b0);
      send_command(rtt_pkg::OP_TICK,   4'd0,  24'd0, 1'b0, 1'b1);   // suspended tick
      send_command(rtt_pkg::OP_TICK,   4'd0,  24'd0, 1'b0, 1'b0);   // both fire together
      send_command(rtt_pkg::OP_SET,    4'd1,  24'd3, 1'b0, 1'b0);   // running continuous
      send_command(rtt_pkg::OP_SET,    4'd0,  24'd4, 1'b0, 1'b0);
      send_command(rtt_pkg::OP_SET,    4'd0,  24'd6, 1'b0, 1'b0);   // re-arm running one-shot
      send_command(rtt_pkg::OP_TICK,   4'd0,  24'd0, 1'b0, 1'b0);
      send_command(rtt_pkg::OP_STOP,   4'd1,  24'd0, 1'b0, 1'b0);
      send_command(rtt_pkg::OP_STOP,   4'd1,  24'd0, 1'b0, 1'b0);
      send_command(rtt_pkg::OP_SET,    4'd1,  24'hFFFFFF, 1'b1, 1'b0);
      send_command(rtt_pkg::OP_STOP,   4'd15, 24'd0, 1'b0, 1'b0);
      for (n = 0; n < 6; n++)
         send_command(rtt_pkg::OP_TICK, 4'd0, 24'd0, 1'b0, 1'b0);
      wait_for_drain();

      // random: mostly short intervals so timers fire often, table fills up early
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 120)
            hold_off_req = 1'b1;
         if (n == 260)
            wait_for_drain();
         pick = $urandom_range(0, 99);
         if (pick < 12)
            op = rtt_pkg::OP_CREATE;
         else if (pick < 42)
            op = rtt_pkg::OP_SET;
         else if (pick < 55)
            op = rtt_pkg::OP_STOP;
         else
            op = rtt_pkg::OP_TICK;
         pick = $urandom_range(0, 99);
         if (pick < 8)
            ivl = '0;
         else if (pick < 70)
            ivl = rtt_pkg::IVL_W'($urandom_range(1, 6));
         else if (pick < 88)
            ivl = rtt_pkg::IVL_W'($urandom_range(7, 64));
         else
            ivl = rtt_pkg::IVL_W'($urandom());
         send_command(op, rtt_pkg::INDEX_W'($urandom_range(0, 15)), ivl,
                      1'($urandom_range(0, 1)), $urandom_range(0, 99) < 15);
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d commands including %0d ticks, %0d results checked",
               commands_sent, ticks_sent, results_checked);
      $display("%0d timer firings seen, up to %0d from a single tick",
               firings_seen, widest_tick);
      if (mismatch_count == 0 && results_owed == 0)
         $display("realtime_timer_table verification clean");
      else
         $display("realtime_timer_table verification failed");
      $finish;
   end

   // result back-pressure: changing styles, plus one long hold-off on request
   initial begin
      int stretch_left;
      int ready_style;
      stretch_left = 0;
      ready_style  = RDY_FREE;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (stretch_left == 0) begin
               ready_style  = $urandom_range(RDY_FREE, RDY_CADENCE);
               stretch_left = $urandom_range(8, 80);
            end
            stretch_left--;
            case (ready_style)
               RDY_FREE:   rsp_tready <= 1'b1;
               RDY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               RDY_SPARSE: rsp_tready <= ($urandom_range(0, 4) == 0);
               default:    rsp_tready <= (stretch_left % 3 == 0);
            endcase
         end
      end
   end

   // watchdog
   initial begin
      #3_000_000;
      $display("realtime_timer_table verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/rtt_pkg.sv
rtl/rtt_front.sv
rtl/rtt_back.sv
rtl/realtime_timer_table.sv
rtl/rtt_checker.sv
dv/timer_table_checker.sv
dv/tb_realtime_timer_table.sv
